/* design/lru_pkg.sv */
// Shared types and constants for the LRU page replacement unit.
package lru_pkg;

    // Stream beat layouts (fixed field widths).
    localparam int IN_W       = 24;
    localparam int OUT_W      = 40;
    localparam int PAGE_W     = 16;
    localparam int SLOT_W     = 4;
    localparam int TOTAL_W    = 16;
    localparam int CFG_W      = 5;

    localparam int IN_PAGE_LSB  = 0;
    localparam int IN_START_BIT = 16;

    localparam int OUT_FAULT_BIT = 0;
    localparam int OUT_SLOT_LSB  = 1;
    localparam int OUT_EVV_BIT   = 5;
    localparam int OUT_EVP_LSB   = 6;
    localparam int OUT_TOT_LSB   = 22;

    localparam logic [TOTAL_W-1:0] FAULT_MAX = '1;

    // Cells per search segment of the LRU chain.
    localparam int SEG = 8;

    typedef enum logic [1:0] {
        OP_HIT,
        OP_FILL,
        OP_EVICT
    } cell_op_t;

    typedef struct packed {
        logic     clear;
        logic     upd;
        cell_op_t op;
    } cell_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_SEL  = 4'b0100,
        ST_UPD  = 4'b1000
    } state_t;

endpackage

/* design/lru_cell.sv */
// One page frame: page number, valid bit, recency rank and a link of the LRU search chain.
module lru_cell #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16,
    parameter int INDEX     = 0,
    localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int CW = $clog2(FRAMES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lru_pkg::cell_cmd_t   cmd,
    input  logic                 target,
    input  logic [PAGE_BITS-1:0] ref_page,
    input  logic [AW-1:0]        ref_age,
    input  logic [CW-1:0]        eff,
    input  logic                 found_in,
    input  logic [AW-1:0]        best_age_in,
    input  logic [AW-1:0]        best_idx_in,
    output logic                 found_out,
    output logic [AW-1:0]        best_age_out,
    output logic [AW-1:0]        best_idx_out,
    output logic                 match,
    output logic                 empty,
    output logic [AW-1:0]        age_q,
    output logic [PAGE_BITS-1:0] page_q
);
    import lru_pkg::*;

    logic                 valid_reg;
    logic [AW-1:0]        age_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 in_use;
    logic                 valid_eff;
    logic                 take;

    // A clear pending for this reference hides the frame from the lookup.
    assign in_use    = CW'(INDEX) < eff;
    assign valid_eff = valid_reg & ~cmd.clear;
    assign match     = in_use & valid_eff & (page_reg == ref_page);
    assign empty     = in_use & ~valid_eff;
    assign age_q     = age_reg;
    assign page_q    = page_reg;

    // Running oldest frame handed on to the next cell.
    assign take         = in_use & valid_eff & (~found_in | (age_reg > best_age_in));
    assign found_out    = found_in | take;
    assign best_age_out = take ? age_reg : best_age_in;
    assign best_idx_out = take ? AW'(INDEX) : best_idx_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end
        else if (cmd.upd)
        begin
            case (cmd.op)
                OP_FILL:
                begin
                    if (target)
                    begin
                        valid_reg <= 1'b1;
                        age_reg   <= '0;
                    end
                    else if (valid_reg)
                    begin
                        age_reg <= age_reg + AW'(1);
                    end
                end
                OP_HIT, OP_EVICT:
                begin
                    if (target)
                    begin
                        age_reg <= '0;
                    end
                    else if (valid_reg && (age_reg < ref_age))
                    begin
                        age_reg <= age_reg + AW'(1);
                    end
                end
                default:
                begin
                    age_reg <= age_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd && target && (cmd.op == OP_FILL || cmd.op == OP_EVICT))
        begin
            page_reg <= ref_page;
        end
    end

endmodule

/* design/lru_page_replacement_unit.sv */
// Top level of the LRU page replacement unit: control, decision registers and cell row.
//
// Usage: each beat on the s_ stream is one page reference (page number and a start
// flag that wipes all frames and the fault count before the lookup). Every reference
// yields exactly one beat on the m_ stream: hit or fault, the frame slot now holding
// the page, the evicted page if any, and the saturating fault total.
// frame_count is written through cfg_we/cfg_wdata while the unit is idle; 0 acts as 1
// and values above FRAMES act as FRAMES.
// Steps: a hit or a fill into an empty frame goes through the compare and update
// states, an eviction also through a select state between them, which merges the
// per-segment oldest-frame results of the cell chain (SEG cells per segment) into
// one victim.
// The result sits in an output register; the next reference is accepted while it
// waits. If the receiver stalls, the following reference stops in its update step
// until the output register frees, and s_tready stays low meanwhile.
// Reset: all frames invalid, ranks and fault count zero, frame_count = FRAMES.
module lru_page_replacement_unit #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lru_pkg::IN_W-1:0]    s_tdata,   // page[15:0], start_new[16], zero
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lru_pkg::OUT_W-1:0]   m_tdata,   // fault, slot[4], evicted_valid,
                                                   // evicted_page[16], fault_total[16]
    input  logic                        cfg_we,
    input  logic [lru_pkg::CFG_W-1:0]   cfg_wdata
);
    import lru_pkg::*;

    localparam int AW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW   = $clog2(FRAMES + 1);
    localparam int FCW  = (CW > CFG_W) ? CW : CFG_W;
    localparam int NSEG = (FRAMES + SEG - 1) / SEG;

    state_t state_reg, state_next;

    logic [FCW-1:0]       frame_count_reg;
    logic [CW-1:0]        eff;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 start_reg;
    logic [TOTAL_W-1:0]   fault_reg;

    logic                 dec_hit_reg;
    logic                 dec_fill_reg;
    logic [FRAMES-1:0]    tgt_oh_reg;
    logic [AW-1:0]        ref_age_reg;
    logic [AW-1:0]        slot_reg;
    logic [PAGE_BITS-1:0] ev_page_reg;
    logic [TOTAL_W-1:0]   total_reg;

    logic                 seg_found_reg [NSEG];
    logic [AW-1:0]        seg_age_reg   [NSEG];
    logic [AW-1:0]        seg_idx_reg   [NSEG];

    logic                 out_valid_reg;
    logic                 out_fault_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic                 out_evv_reg;
    logic [PAGE_W-1:0]    out_evp_reg;
    logic [TOTAL_W-1:0]   out_total_reg;

    logic                 s_acc;
    logic                 load;
    cell_cmd_t            cmd;

    logic [FRAMES-1:0]    match, empty, hit_oh, fill_oh, sel_oh, vic_oh;
    logic                 any_match, any_empty;
    logic [AW-1:0]        sel_idx, hit_age;
    logic [TOTAL_W-1:0]   fault_base, total_next;

    logic                 ch_found [FRAMES];
    logic [AW-1:0]        ch_age   [FRAMES];
    logic [AW-1:0]        ch_idx   [FRAMES];
    logic [AW-1:0]        age_q    [FRAMES];
    logic [PAGE_BITS-1:0] page_q   [FRAMES];

    logic                 best_found;
    logic [AW-1:0]        best_age, best_idx;
    logic [PAGE_BITS-1:0] vic_page;

    // Effective frame count, clamped to 1..FRAMES.
    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            eff = CW'(1);
        end
        else if (frame_count_reg > FCW'(FRAMES))
        begin
            eff = CW'(FRAMES);
        end
        else
        begin
            eff = CW'(frame_count_reg);
        end
    end

    assign load     = ~out_valid_reg | m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_UPD) && load);
    assign s_acc    = s_tvalid & s_tready;

    assign cmd.clear = (state_reg == ST_CMP) & start_reg;
    assign cmd.upd   = (state_reg == ST_UPD) & load;
    assign cmd.op    = dec_hit_reg ? OP_HIT : (dec_fill_reg ? OP_FILL : OP_EVICT);

    genvar g;
    generate
        for (g = 0; g < FRAMES; g++)
        begin : g_cell
            logic          f_in;
            logic [AW-1:0] a_in, i_in;

            if (g % SEG == 0)
            begin : g_head
                assign f_in = 1'b0;
                assign a_in = '0;
                assign i_in = '0;
            end
            else
            begin : g_link
                assign f_in = ch_found[g-1];
                assign a_in = ch_age[g-1];
                assign i_in = ch_idx[g-1];
            end

            lru_cell #(
                .FRAMES    (FRAMES),
                .PAGE_BITS (PAGE_BITS),
                .INDEX     (g)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .cmd          (cmd),
                .target       (tgt_oh_reg[g]),
                .ref_page     (page_reg),
                .ref_age      (ref_age_reg),
                .eff          (eff),
                .found_in     (f_in),
                .best_age_in  (a_in),
                .best_idx_in  (i_in),
                .found_out    (ch_found[g]),
                .best_age_out (ch_age[g]),
                .best_idx_out (ch_idx[g]),
                .match        (match[g]),
                .empty        (empty[g]),
                .age_q        (age_q[g]),
                .page_q       (page_q[g])
            );
        end

        for (g = 0; g < NSEG; g++)
        begin : g_seg
            localparam int LAST = ((g * SEG + SEG - 1) < FRAMES) ? (g * SEG + SEG - 1)
                                                                 : (FRAMES - 1);
            always_ff @(posedge clk)
            begin
                if (state_reg == ST_CMP)
                begin
                    seg_found_reg[g] <= ch_found[LAST];
                    seg_age_reg[g]   <= ch_age[LAST];
                    seg_idx_reg[g]   <= ch_idx[LAST];
                end
            end
        end
    endgenerate

    // Lookup: lowest matching frame wins, else lowest empty frame.
    assign any_match = |match;
    assign any_empty = |empty;
    assign hit_oh    = match & (~match + FRAMES'(1));
    assign fill_oh   = empty & (~empty + FRAMES'(1));
    assign sel_oh    = any_match ? hit_oh : fill_oh;

    always_comb
    begin
        sel_idx = '0;
        hit_age = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (sel_oh[i])
            begin
                sel_idx = sel_idx | AW'(i);
            end
            if (hit_oh[i])
            begin
                hit_age = hit_age | age_q[i];
            end
        end
    end

    assign fault_base = start_reg ? '0 : fault_reg;
    assign total_next = (!any_match && (fault_base != FAULT_MAX)) ? fault_base + TOTAL_W'(1)
                                                                  : fault_base;

    // Merge the segment results into the victim frame.
    always_comb
    begin
        best_found = 1'b0;
        best_age   = '0;
        best_idx   = '0;
        for (int s = 0; s < NSEG; s++)
        begin
            if (seg_found_reg[s] && (!best_found || (seg_age_reg[s] > best_age)))
            begin
                best_found = 1'b1;
                best_age   = seg_age_reg[s];
                best_idx   = seg_idx_reg[s];
            end
        end
    end

    always_comb
    begin
        vic_page = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            vic_oh[i] = (best_idx == AW'(i));
            if (vic_oh[i])
            begin
                vic_page = vic_page | page_q[i];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = (any_match || any_empty) ? ST_UPD : ST_SEL;
            end
            ST_SEL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (load)
                begin
                    state_next = s_acc ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            frame_count_reg <= FCW'(FRAMES);
            fault_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                frame_count_reg <= FCW'(cfg_wdata);
            end
            if (state_reg == ST_CMP)
            begin
                fault_reg <= total_next;
            end
            if (cmd.upd)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            page_reg  <= PAGE_BITS'(s_tdata[IN_PAGE_LSB +: PAGE_W]);
            start_reg <= s_tdata[IN_START_BIT];
        end
        if (state_reg == ST_CMP)
        begin
            dec_hit_reg  <= any_match;
            dec_fill_reg <= ~any_match & any_empty;
            tgt_oh_reg   <= sel_oh;
            ref_age_reg  <= hit_age;
            slot_reg     <= sel_idx;
            total_reg    <= total_next;
        end
        else if (state_reg == ST_SEL)
        begin
            tgt_oh_reg  <= vic_oh;
            ref_age_reg <= best_age;
            slot_reg    <= best_idx;
            ev_page_reg <= vic_page;
        end
        if (cmd.upd)
        begin
            out_fault_reg <= ~dec_hit_reg;
            out_slot_reg  <= SLOT_W'(slot_reg);
            out_evv_reg   <= ~dec_hit_reg & ~dec_fill_reg;
            out_evp_reg   <= (~dec_hit_reg & ~dec_fill_reg) ? PAGE_W'(ev_page_reg) : '0;
            out_total_reg <= total_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - OUT_TOT_LSB - TOTAL_W){1'b0}}, out_total_reg, out_evp_reg,
                       out_evv_reg, out_slot_reg, out_fault_reg};

endmodule

/* design/lru_chk.sv */
// Port-level checker for the LRU page replacement unit, bound to the top level.
module lru_chk (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [lru_pkg::OUT_W-1:0] m_tdata
);
    import lru_pkg::*;

    logic                 o_fault;
    logic                 o_evv;
    logic [PAGE_W-1:0]    o_evp;
    logic [TOTAL_W-1:0]   o_total;

    assign o_fault = m_tdata[OUT_FAULT_BIT];
    assign o_evv   = m_tdata[OUT_EVV_BIT];
    assign o_evp   = m_tdata[OUT_EVP_LSB +: PAGE_W];
    assign o_total = m_tdata[OUT_TOT_LSB +: TOTAL_W];

    // A stalled result beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Only a fault can evict a page.
    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && o_evv |-> o_fault)
        else $error("eviction reported on a hit");

    // The evicted page field is zero when nothing was evicted.
    a_evp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !o_evv |-> o_evp == '0)
        else $error("evicted page nonzero without eviction");

    // A fault always leaves a nonzero fault total.
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && o_fault |-> o_total != '0)
        else $error("fault reported with zero fault total");

    // The handshake outputs are always known once reset is released.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_tready, m_tvalid}))
        else $error("handshake output unknown");

endmodule

bind lru_page_replacement_unit lru_chk u_lru_chk (.*);

/* tb/tb_lru_page_replacement_unit.sv */
// Self-checking testbench for the LRU page replacement unit: directed rows, random traffic, checks.
`timescale 1ns / 1ps

module tb_lru_page_replacement_unit;
    import lru_pkg::*;

    localparam int NFRAMES     = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_REFS  = 48;

    typedef struct packed {
        logic              fault;
        logic [SLOT_W-1:0] slot;
        logic              ev_valid;
        logic [PAGE_W-1:0] ev_page;
        logic [TOTAL_W-1:0] total;
    } page_result_t;

    // One directed row: optional frame count write first, then one reference.
    typedef struct packed {
        bit                cfg_en;
        logic [CFG_W-1:0]  cfg_val;
        logic [PAGE_W-1:0] page;
        bit                start_new;
        bit                typed;
        page_result_t      res;
    } ref_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_we = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // Predictor state.
    logic [PAGE_W-1:0]  fr_page [NFRAMES];
    bit                 fr_valid [NFRAMES];
    logic [7:0]         fr_rank [NFRAMES];
    logic [TOTAL_W-1:0] fault_tally;
    logic [CFG_W-1:0]   frames_cfg;

    page_result_t pending_results [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int errors = 0;
    int cycle_cnt = 0;
    int refs_sent = 0;
    int hits_seen = 0;
    int faults_seen = 0;
    int evictions_seen = 0;
    logic [PAGE_W-1:0] page_pool [40];
    int pool_n = 1;

    ref_row_t dir_rows [0:21] = '{
        '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 16'd1}},
        '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 16'd2}},
        '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 16'd2}},
        '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 16'd2}},
        '{1'b0, 5'd0,  16'h00FF, 1'b1, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 16'd1}},
        '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 16'd2}},
        '{1'b1, 5'd1,  16'h1234, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b1, 16'h00FF, 16'd3}},
        '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b1, 16'h1234, 16'd4}},
        '{1'b1, 5'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 16'd4}},
        '{1'b1, 5'd31, 16'hFFFF, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 16'd4}},
        '{1'b0, 5'd0,  16'h8001, 1'b0, 1'b1, '{1'b1, 4'd2, 1'b0, 16'h0000, 16'd5}},
        '{1'b0, 5'd0,  16'hAAAA, 1'b1, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 16'd1}},
        '{1'b0, 5'd0,  16'h5555, 1'b0, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 16'd2}},
        '{1'b1, 5'd4,  16'h0100, 1'b0, 1'b1, '{1'b1, 4'd2, 1'b0, 16'h0000, 16'd3}},
        '{1'b0, 5'd0,  16'h0200, 1'b0, 1'b1, '{1'b1, 4'd3, 1'b0, 16'h0000, 16'd4}},
        '{1'b0, 5'd0,  16'h0300, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b1, 16'hAAAA, 16'd5}},
        '{1'b0, 5'd0,  16'h5555, 1'b0, 1'b0, '0},
        '{1'b0, 5'd0,  16'h0400, 1'b0, 1'b0, '0},
        '{1'b0, 5'd0,  16'h0100, 1'b0, 1'b0, '0},
        '{1'b0, 5'd0,  16'h0200, 1'b0, 1'b0, '0},
        '{1'b1, 5'd16, 16'h0300, 1'b0, 1'b0, '0},
        '{1'b0, 5'd0,  16'h8000, 1'b0, 1'b0, '0}
    };

    lru_page_replacement_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_frames();
        for (int i = 0; i < NFRAMES; i++)
        begin
            fr_page[i] = '0;
            fr_valid[i] = 1'b0;
            fr_rank[i] = '0;
        end
        fault_tally = '0;
    endfunction

    // Frame idx becomes most recent; every valid frame younger than it ages by one.
    function automatic void promote(input int idx);
        logic [7:0] a;
        a = fr_rank[idx];
        for (int i = 0; i < NFRAMES; i++)
            if (i != idx && fr_valid[i] && fr_rank[i] < a)
                fr_rank[i] = fr_rank[i] + 8'd1;
        fr_rank[idx] = '0;
    endfunction

    function automatic page_result_t lookup_page(input logic [PAGE_W-1:0] pg, input bit st);
        page_result_t r;
        int eff;
        int hit_i;
        int free_i;
        int old_i;
        logic [7:0] best;
        r = '0;
        if (st)
            clear_frames();
        eff = int'(frames_cfg);
        if (eff < 1)
            eff = 1;
        if (eff > NFRAMES)
            eff = NFRAMES;
        hit_i = -1;
        for (int i = 0; i < eff; i++)
            if (hit_i < 0 && fr_valid[i] && fr_page[i] == pg)
                hit_i = i;
        if (hit_i >= 0)
        begin
            promote(hit_i);
            r.slot = hit_i[SLOT_W-1:0];
        end
        else
        begin
            r.fault = 1'b1;
            if (fault_tally != FAULT_MAX)
                fault_tally = fault_tally + 1'b1;
            free_i = -1;
            for (int i = 0; i < eff; i++)
                if (free_i < 0 && !fr_valid[i])
                    free_i = i;
            if (free_i >= 0)
            begin
                // A fresh frame joins the set, so everything resident ages one step.
                for (int i = 0; i < NFRAMES; i++)
                    if (fr_valid[i])
                        fr_rank[i] = fr_rank[i] + 8'd1;
                fr_valid[free_i] = 1'b1;
                fr_rank[free_i] = '0;
                fr_page[free_i] = pg;
                r.slot = free_i[SLOT_W-1:0];
            end
            else
            begin
                best = '0;
                old_i = 0;
                for (int i = 0; i < eff; i++)
                    if (fr_rank[i] > best)
                    begin
                        best = fr_rank[i];
                        old_i = i;
                    end
                r.ev_valid = 1'b1;
                r.ev_page = fr_page[old_i];
                fr_page[old_i] = pg;
                promote(old_i);
                r.slot = old_i[SLOT_W-1:0];
            end
        end
        r.total = fault_tally;
        return r;
    endfunction

    function automatic logic [PAGE_W-1:0] next_page();
        if ($urandom_range(0, 99) < 12)
            return PAGE_W'($urandom);
        return page_pool[$urandom_range(0, pool_n - 1)];
    endfunction

    // Offers one reference; predicts its result at the beat where it is taken.
    task automatic send_ref(input logic [PAGE_W-1:0] pg, input bit st, input bit typed,
                            input page_result_t want);
        logic [IN_W-1:0] beat;
        page_result_t pred;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        beat = '0;
        beat[IN_PAGE_LSB +: PAGE_W] = pg;
        beat[IN_START_BIT] = st;
        s_tvalid <= 1'b1;
        s_tdata <= beat;
        do
            @(posedge clk);
        while (!s_tready);
        pred = lookup_page(pg, st);
        pending_results.push_back(typed ? want : pred);
        refs_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_frames(input logic [CFG_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        frames_cfg = v;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off whenever hold_seq moves.
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        page_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected, got 0x%0h", $time, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("fault", 32'(want.fault), 32'(m_tdata[OUT_FAULT_BIT]));
                check_field("slot", 32'(want.slot), 32'(m_tdata[OUT_SLOT_LSB +: SLOT_W]));
                check_field("evicted_valid", 32'(want.ev_valid), 32'(m_tdata[OUT_EVV_BIT]));
                check_field("evicted_page", 32'(want.ev_page),
                            32'(m_tdata[OUT_EVP_LSB +: PAGE_W]));
                check_field("fault_total", 32'(want.total),
                            32'(m_tdata[OUT_TOT_LSB +: TOTAL_W]));
                if (m_tdata[OUT_FAULT_BIT])
                    faults_seen++;
                else
                    hits_seen++;
                if (m_tdata[OUT_EVV_BIT])
                    evictions_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_W-1:0] phase_frames [8];
        int idle_mode [4];
        int stall_mode [4];
        int eff;

        phase_frames = '{5'd16, 5'd1, 5'd3, 5'd8, 5'd31, 5'd0, 5'd20, 5'd5};
        idle_mode = '{0, 65, 0, 9};
        stall_mode = '{0, 0, 65, 9};
        clear_frames();
        frames_cfg = CFG_W'(NFRAMES);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; the frame count starts at its reset value.
        foreach (dir_rows[k])
        begin
            if (dir_rows[k].cfg_en)
                set_frames(dir_rows[k].cfg_val);
            send_ref(dir_rows[k].page, dir_rows[k].start_new, dir_rows[k].typed,
                     dir_rows[k].res);
        end

        // Random phases: a working set a bit larger than the frame count gives
        // a mix of hits, fills and evictions.
        for (int p = 0; p < 8; p++)
        begin
            set_frames(phase_frames[p]);
            send_idle_pct = idle_mode[p % 4];
            stall_pct = stall_mode[p % 4];
            eff = int'(phase_frames[p]);
            if (eff < 1)
                eff = 1;
            if (eff > NFRAMES)
                eff = NFRAMES;
            pool_n = eff + $urandom_range(1, eff + 1);
            for (int i = 0; i < pool_n; i++)
                page_pool[i] = PAGE_W'($urandom);
            for (int n = 0; n < PHASE_REFS; n++)
                send_ref(next_page(), $urandom_range(0, 99) < 3, 1'b0, '0);
        end

        // Back-pressure: the receiver holds off while references keep coming,
        // then the sender waits for every outstanding result.
        set_frames(5'd8);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_seq <= hold_seq + 1;
        for (int n = 0; n < 40; n++)
            send_ref(next_page(), 1'b0, 1'b0, '0);
        drain();
        repeat (8) @(posedge clk);

        $display("Sent %0d page references: %0d hits, %0d faults, %0d evictions.",
                 refs_sent, hits_seen, faults_seen, evictions_seen);
        $display("Frame counts 0 to 31, random stalls and idles, and a long receiver hold-off.");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
